/* rtl/dtl_pkg.sv */
// ----------------------------------------------------------------------------
// dtl_pkg: shared types and constants for the token lexer
// Token kinds, lexer modes, word types and the front-to-back record.
// ----------------------------------------------------------------------------
`default_nettype none
package dtl_pkg;

  localparam int unsigned MaxTokenLenDef = 255;
  localparam int unsigned PosWidthDef    = 16;

  localparam logic [4:0] K_IDENT = 5'd0;
  localparam logic [4:0] K_FUNC  = 5'd1;
  localparam logic [4:0] K_RET   = 5'd2;
  localparam logic [4:0] K_BIT   = 5'd3;
  localparam logic [4:0] K_HEX   = 5'd4;
  localparam logic [4:0] K_EQEQ  = 5'd5;
  localparam logic [4:0] K_NEQ   = 5'd6;
  localparam logic [4:0] K_ANDAND = 5'd7;
  localparam logic [4:0] K_OROR  = 5'd8;
  localparam logic [4:0] K_SHL   = 5'd9;
  localparam logic [4:0] K_SHR   = 5'd10;
  localparam logic [4:0] K_ASHL  = 5'd11;
  localparam logic [4:0] K_ASHR  = 5'd12;
  localparam logic [4:0] K_SCOPE = 5'd13;
  localparam logic [4:0] K_ASSIGN = 5'd14;
  localparam logic [4:0] K_PIPE  = 5'd15;
  localparam logic [4:0] K_AMP   = 5'd16;
  localparam logic [4:0] K_CARET = 5'd17;
  localparam logic [4:0] K_TILDE = 5'd18;
  localparam logic [4:0] K_COLON = 5'd19;
  localparam logic [4:0] K_SEMI  = 5'd20;
  localparam logic [4:0] K_LBRACE = 5'd21;
  localparam logic [4:0] K_RBRACE = 5'd22;
  localparam logic [4:0] K_LPAREN = 5'd23;
  localparam logic [4:0] K_RPAREN = 5'd24;
  localparam logic [4:0] K_LBRACK = 5'd25;
  localparam logic [4:0] K_RBRACK = 5'd26;
  localparam logic [4:0] K_EOF   = 5'd27;
  localparam logic [4:0] K_ERR   = 5'd28;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_ZERO, M_DEC, M_HEX, M_LT, M_LTLT, M_GT, M_GTGT,
    M_EQ, M_BANG, M_AMP, M_PIPE, M_COLON
  } mode_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_source;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic [7:0]  token_length;
    logic        last_of_run;
  } out_word_t;

  // one decoded character event from the front end: up to two tokens
  typedef struct packed {
    logic      n0;       // first token present
    out_word_t t0;
    logic      n1;       // second token present
    out_word_t t1;
  } evt_t;

endpackage
`default_nettype wire

/* rtl/dsl_token_lexer.sv */
// ----------------------------------------------------------------------------
// dsl_token_lexer: streaming maximal-munch lexer
// Front end decodes one character word per cycle unless stalled; a four-entry
// queue feeds the back end, which sends a token word per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel | dir | payload    | handshake
//  in      | in  | in_word_t  | in_valid_i / in_stall_o
//  out     | out | out_word_t | out_valid_o / out_stall_i
//
// One character word is accepted per cycle while the queue has room.
// A word that yields two tokens is sent as two token words; the back end
// drains a token per cycle unless stalled, so sustained input rate follows it.
// Reset clears position to line 1 column 1 and empties the queue.
// in_stall_o rises when the queue holds four events.
// ----------------------------------------------------------------------------
`default_nettype none
module dsl_token_lexer #(
  parameter int unsigned MaxTokenLen = dtl_pkg::MaxTokenLenDef,
  parameter int unsigned PosWidth    = dtl_pkg::PosWidthDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  dtl_pkg::in_word_t   in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output dtl_pkg::out_word_t  out_data_o
);
  import dtl_pkg::*;

  evt_t evt;
  logic full, step;

  assign in_stall_o = full;
  assign step = in_valid_i && !full;

  dtl_front #(.MaxTokenLen(MaxTokenLen), .PosWidth(PosWidth)) u_front (
    .clk_i, .rst_ni, .step_i(step), .word_i(in_data_i), .evt_o(evt)
  );

  // words that produce no token never enter the queue
  dtl_back u_back (
    .clk_i, .rst_ni, .push_i(step && (evt.n0 || evt.n1)), .evt_i(evt),
    .full_o(full), .valid_o(out_valid_o), .stall_i(out_stall_i),
    .data_o(out_data_o)
  );
endmodule
`default_nettype wire

/* rtl/dtl_front.sv */
// ----------------------------------------------------------------------------
// dtl_front: character classifier and pending-token tracker
// Consumes one word per cycle while step_i is high; up to two tokens per word.
// ----------------------------------------------------------------------------
`default_nettype none
module dtl_front #(
  parameter int unsigned MaxTokenLen = dtl_pkg::MaxTokenLenDef,
  parameter int unsigned PosWidth    = dtl_pkg::PosWidthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  dtl_pkg::in_word_t     word_i,
  output dtl_pkg::evt_t         evt_o
);
  import dtl_pkg::*;

  localparam int unsigned LenW = $clog2(MaxTokenLen + 1);
  localparam logic [PosWidth-1:0] PosMax = {PosWidth{1'b1}};
  localparam logic [LenW-1:0] LenMax = LenW'(MaxTokenLen);

  mode_e mode_q, mode_d;
  logic [PosWidth-1:0] line_q, line_d, col_q, col_d, sl_q, sl_d, sc_q, sc_d;
  logic [LenW-1:0] len_q, len_d;
  logic [1:0] kw_q, kw_d;
  logic err_q, err_d;

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic logic is_hexd(logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction
  function automatic logic [7:0] kwf(logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = "f"; 3'd1: r = "u"; 3'd2: r = "n"; 3'd3: r = "c";
      3'd4: r = "t"; 3'd5: r = "i"; 3'd6: r = "o"; default: r = "n";
    endcase
    return r;
  endfunction
  function automatic logic [7:0] kwr(logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = "r"; 3'd1: r = "e"; 3'd2: r = "t"; 3'd3: r = "u";
      3'd4: r = "r"; default: r = "n";
    endcase
    return r;
  endfunction

  function automatic out_word_t mk(logic [4:0] k, logic [PosWidth-1:0] l,
                                   logic [PosWidth-1:0] c, logic [LenW-1:0] n);
    out_word_t w;
    w.token_kind   = k;
    w.token_line   = 16'(l);
    w.token_column = 16'(c);
    w.token_length = 8'(n);
    w.last_of_run  = 1'b0;
    return w;
  endfunction

  logic [7:0] c;
  logic [4:0] fk, single;
  logic ext, done, sp;
  logic [4:0] dk;
  logic [1:0] km;
  logic [LenW-1:0] len_inc;
  mode_e ext_mode;
  logic go_start;

  always_comb begin
    c = word_i.char_code;
    sp = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    // flush kind of the pending token
    unique case (mode_q)
      M_IDENT: begin
        if (kw_q[0] && len_q == LenW'(8)) fk = K_FUNC;
        else if (kw_q[1] && len_q == LenW'(6)) fk = K_RET;
        else fk = K_IDENT;
      end
      M_ZERO, M_DEC: fk = K_BIT;
      M_HEX:   fk = K_HEX;
      M_LTLT:  fk = K_SHL;
      M_GTGT:  fk = K_SHR;
      M_EQ:    fk = K_ASSIGN;
      M_PIPE:  fk = K_PIPE;
      M_AMP:   fk = K_AMP;
      M_COLON: fk = K_COLON;
      default: fk = K_ERR;
    endcase
    ext = 1'b0; done = 1'b0; dk = K_ERR; ext_mode = mode_q;
    unique case (mode_q)
      M_IDENT: ext = is_alpha(c) || is_digit(c) || c == "_";
      M_ZERO: begin
        if (c == "x" || c == "X") begin ext = 1'b1; ext_mode = M_HEX; end
        else if (is_digit(c)) begin ext = 1'b1; ext_mode = M_DEC; end
      end
      M_DEC: ext = is_digit(c);
      M_HEX: ext = is_hexd(c);
      M_LT: if (c == "<") begin ext = 1'b1; ext_mode = M_LTLT; end
      M_GT: if (c == ">") begin ext = 1'b1; ext_mode = M_GTGT; end
      M_LTLT: if (c == "<") begin ext = 1'b1; done = 1'b1; dk = K_ASHL; end
      M_GTGT: if (c == ">") begin ext = 1'b1; done = 1'b1; dk = K_ASHR; end
      M_EQ: if (c == "=") begin ext = 1'b1; done = 1'b1; dk = K_EQEQ; end
      M_BANG: if (c == "=") begin ext = 1'b1; done = 1'b1; dk = K_NEQ; end
      M_AMP: if (c == "&") begin ext = 1'b1; done = 1'b1; dk = K_ANDAND; end
      M_PIPE: if (c == "|") begin ext = 1'b1; done = 1'b1; dk = K_OROR; end
      M_COLON: if (c == ":") begin ext = 1'b1; done = 1'b1; dk = K_SCOPE; end
      default: ;
    endcase
    km = 2'b00;
    if (kw_q[0] && len_q < LenW'(8) && c == kwf(len_q[2:0])) km[0] = 1'b1;
    if (kw_q[1] && len_q < LenW'(6) && c == kwr(len_q[2:0])) km[1] = 1'b1;
    len_inc = (len_q < LenMax) ? len_q + 1'b1 : len_q;

    mode_d = mode_q; line_d = line_q; col_d = col_q; sl_d = sl_q; sc_d = sc_q;
    len_d = len_q; kw_d = kw_q; err_d = err_q;
    evt_o = '0;
    go_start = 1'b0;
    single = '0;

    if (word_i.end_of_source) begin
      if (!err_q && mode_q != M_IDLE) begin
        evt_o.n0 = 1'b1;
        evt_o.t0 = mk(fk, sl_q, sc_q, (fk == K_ERR) ? LenW'(1) : len_q);
      end
      if (!err_q && !(mode_q != M_IDLE && fk == K_ERR)) begin
        evt_o.n1 = 1'b1;
        evt_o.t1 = mk(K_EOF, line_q, col_q, '0);
      end
      mode_d = M_IDLE; line_d = PosWidth'(1); col_d = PosWidth'(1);
      sl_d = '0; sc_d = '0; len_d = '0; kw_d = '0; err_d = 1'b0;
    end else if (!err_q) begin
      if (mode_q != M_IDLE && ext) begin
        if (mode_q == M_IDENT) kw_d = km;
        mode_d = ext_mode;
        len_d = len_inc;
        if (done) begin
          evt_o.n0 = 1'b1;
          evt_o.t0 = mk(dk, sl_q, sc_q, len_inc);
          mode_d = M_IDLE; len_d = '0;
        end
      end else begin
        if (mode_q != M_IDLE) begin
          evt_o.n0 = 1'b1;
          evt_o.t0 = mk(fk, sl_q, sc_q, (fk == K_ERR) ? LenW'(1) : len_q);
          mode_d = M_IDLE; len_d = '0;
          if (fk == K_ERR) err_d = 1'b1;
        end
        go_start = !(mode_q != M_IDLE && fk == K_ERR) && !sp;
      end
      if (go_start) begin
        sl_d = line_q; sc_d = col_q; len_d = LenW'(1);
        if (is_alpha(c) || c == "_") begin
          mode_d = M_IDENT; kw_d = {c == "r", c == "f"};
        end else if (c == "0") mode_d = M_ZERO;
        else if (is_digit(c)) mode_d = M_DEC;
        else if (c == "<") mode_d = M_LT;
        else if (c == ">") mode_d = M_GT;
        else if (c == "=") mode_d = M_EQ;
        else if (c == "!") mode_d = M_BANG;
        else if (c == "&") mode_d = M_AMP;
        else if (c == "|") mode_d = M_PIPE;
        else if (c == ":") mode_d = M_COLON;
        else begin
          case (c)
            "^": single = K_CARET;
            "~": single = K_TILDE;
            ";": single = K_SEMI;
            "{": single = K_LBRACE;
            "}": single = K_RBRACE;
            "(": single = K_LPAREN;
            ")": single = K_RPAREN;
            "[": single = K_LBRACK;
            "]": single = K_RBRACK;
            default: single = K_ERR;
          endcase
          len_d = '0;
          // single token goes in slot 1; slot 0 may hold the flushed one
          evt_o.n1 = 1'b1;
          evt_o.t1 = mk(single, line_q, col_q, LenW'(1));
          if (single == K_ERR) err_d = 1'b1;
        end
      end
      // position advances unless this byte raised a flush error
      if (!(mode_q != M_IDLE && !ext && fk == K_ERR)) begin
        if (c == 8'd10) begin
          if (line_q < PosMax) line_d = line_q + 1'b1;
          col_d = PosWidth'(1);
        end else if (col_q < PosMax) col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; line_q <= PosWidth'(1); col_q <= PosWidth'(1);
      sl_q <= '0; sc_q <= '0; len_q <= '0; kw_q <= '0; err_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d; line_q <= line_d; col_q <= col_d;
      sl_q <= sl_d; sc_q <= sc_d; len_q <= len_d; kw_q <= kw_d; err_q <= err_d;
    end
  end
endmodule
`default_nettype wire

/* rtl/dtl_back.sv */
// ----------------------------------------------------------------------------
// dtl_back: event queue and token serializer
// Queues decoded events; sends their tokens one word per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module dtl_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  dtl_pkg::evt_t       evt_i,
  output logic                full_o,
  output logic                valid_o,
  input  wire logic           stall_i,
  output dtl_pkg::out_word_t  data_o
);
  import dtl_pkg::*;

  localparam int unsigned Depth = 4;
  evt_t mem_q [Depth];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic half_q;  // first token of head already sent
  logic pop, has0, has1, last_tok;
  evt_t head;

  always_comb begin
    head = mem_q[rp_q];
    has0 = head.n0 && !half_q;
    has1 = head.n1;
    valid_o = cnt_q != 3'd0;
    data_o = has0 ? head.t0 : head.t1;
    last_tok = !(has0 && has1);
    data_o.last_of_run = last_tok;
    pop = valid_o && !stall_i && last_tok;
    // stall while every entry holds an event; a push only comes while not full
    full_o = cnt_q == 3'(Depth);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= evt_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0; half_q <= 1'b0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop);
      if (pop) half_q <= 1'b0;
      else if (valid_o && !stall_i) half_q <= 1'b1;
    end
  end
endmodule
`default_nettype wire

/* bench/tb_dsl_token_lexer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dsl_token_lexer: self-checking bench for the streaming token lexer
// Feeds character words (directed snippets, well-formed DSL text, noise),
// predicts the token words in a behavioral lexer model and compares each
// token word field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_dsl_token_lexer;
  import dtl_pkg::*;

  localparam int unsigned LenMax = 255;
  localparam int unsigned PosMax = 65535;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_data_o;

  dsl_token_lexer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // lexer state of the predictor
  mode_e       lx_mode;
  int unsigned lx_line, lx_col, lx_sline, lx_scol, lx_len;
  logic [1:0]  lx_kw;     // bit0: still "function", bit1: still "return"
  logic        lx_err;

  out_word_t   token_q[$];
  int          fail_cnt;
  bit          quiet;     // suppresses idling during the no-gap stretch

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic bit is_ws(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction
  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit is_alf(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic bit is_hexd(logic [7:0] c);
    return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  task automatic lx_clear();
    lx_mode = M_IDLE; lx_line = 1; lx_col = 1; lx_sline = 0; lx_scol = 0;
    lx_len = 0; lx_kw = 2'b00; lx_err = 1'b0;
  endtask

  function automatic void push_token(logic [4:0] k, int unsigned ln, int unsigned col,
                                     int unsigned len);
    out_word_t w;
    w.token_kind   = k;
    w.token_line   = ln[15:0];
    w.token_column = col[15:0];
    w.token_length = len[7:0];
    w.last_of_run  = 1'b0;
    token_q = {token_q, w};
  endfunction

  function automatic logic [4:0] pending_kind();
    case (lx_mode)
      M_IDENT: begin
        if (lx_kw[0] && lx_len == 8) return K_FUNC;
        if (lx_kw[1] && lx_len == 6) return K_RET;
        return K_IDENT;
      end
      M_ZERO, M_DEC: return K_BIT;
      M_HEX:   return K_HEX;
      M_LTLT:  return K_SHL;
      M_GTGT:  return K_SHR;
      M_EQ:    return K_ASSIGN;
      M_PIPE:  return K_PIPE;
      M_AMP:   return K_AMP;
      M_COLON: return K_COLON;
      default: return K_ERR;
    endcase
  endfunction

  task automatic step_pos(logic [7:0] c);
    if (c == 8'd10) begin
      if (lx_line < PosMax) lx_line++;
      lx_col = 1;
    end else if (lx_col < PosMax) lx_col++;
  endtask

  // emit pending token; returns 1 if it was an error
  function automatic bit flush_pending();
    logic [4:0] k;
    k = pending_kind();
    push_token(k, lx_sline, lx_scol, k == K_ERR ? 1 : lx_len);
    return k == K_ERR;
  endfunction

  // predicts the token words caused by one character word
  task automatic lex_word(in_word_t w);
    int          n0;
    logic [7:0]  c;
    bit          ext;
    logic [4:0]  done_k;
    logic [4:0]  one;
    string       fn, rt;
    fn = "function"; rt = "return";
    n0 = token_q.size();
    c  = w.char_code;
    if (w.end_of_source) begin
      if (!lx_err && lx_mode != M_IDLE) lx_err = flush_pending();
      if (!lx_err) push_token(K_EOF, lx_line, lx_col, 0);
      lx_clear();
    end else if (!lx_err) begin
      if (lx_mode != M_IDLE) begin
        ext = 1'b0; done_k = K_ERR;
        case (lx_mode)
          M_IDENT: ext = is_alf(c) || is_dig(c) || c == "_";
          M_ZERO: begin
            if (c == "x" || c == "X") begin lx_mode = M_HEX; ext = 1; end
            else if (is_dig(c)) begin lx_mode = M_DEC; ext = 1; end
          end
          M_DEC:   ext = is_dig(c);
          M_HEX:   ext = is_hexd(c);
          M_LT:    if (c == "<") begin lx_mode = M_LTLT; ext = 1; end
          M_GT:    if (c == ">") begin lx_mode = M_GTGT; ext = 1; end
          M_LTLT:  if (c == "<") begin ext = 1; done_k = K_ASHL; end
          M_GTGT:  if (c == ">") begin ext = 1; done_k = K_ASHR; end
          M_EQ:    if (c == "=") begin ext = 1; done_k = K_EQEQ; end
          M_BANG:  if (c == "=") begin ext = 1; done_k = K_NEQ; end
          M_AMP:   if (c == "&") begin ext = 1; done_k = K_ANDAND; end
          M_PIPE:  if (c == "|") begin ext = 1; done_k = K_OROR; end
          M_COLON: if (c == ":") begin ext = 1; done_k = K_SCOPE; end
          default: ;
        endcase
        if (ext) begin
          if (lx_mode == M_IDENT)
            lx_kw = {lx_kw[1] && lx_len < 6 && c == rt[lx_len],
                     lx_kw[0] && lx_len < 8 && c == fn[lx_len]};
          if (lx_len < LenMax) lx_len++;
          if (done_k != K_ERR) begin
            push_token(done_k, lx_sline, lx_scol, lx_len);
            lx_mode = M_IDLE; lx_len = 0;
          end
          step_pos(c);
          mark_last(n0);
          return;
        end
        lx_err = flush_pending();
        lx_mode = M_IDLE; lx_len = 0;
        if (lx_err) begin
          mark_last(n0);
          return;
        end
      end
      if (!is_ws(c)) begin
        one = K_IDENT;  // K_IDENT marks "multi-char start"
        lx_sline = lx_line; lx_scol = lx_col; lx_len = 1;
        if (is_alf(c) || c == "_") begin
          lx_mode = M_IDENT; lx_kw = {c == "r", c == "f"};
        end else if (c == "0") lx_mode = M_ZERO;
        else if (is_dig(c)) lx_mode = M_DEC;
        else if (c == "<") lx_mode = M_LT;
        else if (c == ">") lx_mode = M_GT;
        else if (c == "=") lx_mode = M_EQ;
        else if (c == "!") lx_mode = M_BANG;
        else if (c == "&") lx_mode = M_AMP;
        else if (c == "|") lx_mode = M_PIPE;
        else if (c == ":") lx_mode = M_COLON;
        else if (c == "^") one = K_CARET;
        else if (c == "~") one = K_TILDE;
        else if (c == ";") one = K_SEMI;
        else if (c == "{") one = K_LBRACE;
        else if (c == "}") one = K_RBRACE;
        else if (c == "(") one = K_LPAREN;
        else if (c == ")") one = K_RPAREN;
        else if (c == "[") one = K_LBRACK;
        else if (c == "]") one = K_RBRACK;
        else one = K_ERR;
        if (one != K_IDENT) begin
          push_token(one, lx_sline, lx_scol, 1);
          lx_len = 0;
          if (one == K_ERR) begin
            lx_err = 1'b1;
            mark_last(n0);
            return;
          end
        end
      end
      step_pos(c);
    end
    mark_last(n0);
  endtask

  task automatic mark_last(int n0);
    if (token_q.size() > n0) token_q[token_q.size()-1].last_of_run = 1'b1;
  endtask

  // send one character word; predicts at acceptance
  task automatic send_word(logic [7:0] c, bit eos);
    in_word_t w;
    w.char_code = c; w.end_of_source = eos;
    while (!quiet && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    lex_word(w);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic end_source();
    send_word(8'h00, 1'b1);
  endtask

  // token checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (token_q.size() == 0) begin
        $error("unexpected token word %p", out_data_o);
        fail_cnt++;
      end else begin
        out_word_t e;
        e = token_q.pop_front();
        if (out_data_o.token_kind !== e.token_kind) begin
          $error("token_kind exp %0d got %0d", e.token_kind, out_data_o.token_kind);
          fail_cnt++;
        end
        if (out_data_o.token_line !== e.token_line) begin
          $error("token_line exp %0d got %0d", e.token_line, out_data_o.token_line);
          fail_cnt++;
        end
        if (out_data_o.token_column !== e.token_column) begin
          $error("token_column exp %0d got %0d", e.token_column,
                 out_data_o.token_column);
          fail_cnt++;
        end
        if (out_data_o.token_length !== e.token_length) begin
          $error("token_length exp %0d got %0d", e.token_length,
                 out_data_o.token_length);
          fail_cnt++;
        end
        if (out_data_o.last_of_run !== e.last_of_run) begin
          $error("last_of_run exp %0d got %0d", e.last_of_run, out_data_o.last_of_run);
          fail_cnt++;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 30);
  end

  // ---- tests ----
  task automatic test_keywords_idents();
    send_text("function return func functions returnx _a9 Zz r f\n");
    end_source();
  endtask

  task automatic test_literals();
    send_text("0 0x 0XfF 0123 987 0x1g 00x ");
    send_word("0", 1'b0);
    end_source();                 // literal flushed at end marker
  endtask

  task automatic test_operators();
    send_text("== != && || << >> <<< >>> :: = | & ^ ~ : ; { } ( ) [ ]\t<<<<=");
    end_source();
  endtask

  task automatic test_errors();
    send_text("a <b x");          // lone '<' followed by a letter
    end_source();
    send_text(">");               // lone '>' flushed by end marker
    end_source();
    send_text("!x");
    end_source();
    send_word(8'h00, 1'b0);       // NUL
    send_word(8'hFF, 1'b0);       // ignored after error
    end_source();
    send_word(8'h80, 1'b0);
    end_source();
    send_word(8'h7F, 1'b0);       // DEL, then an end marker with char bits set
    send_word(8'hFF, 1'b1);
  endtask

  task automatic test_long_token();
    // identifier longer than the length limit
    for (int i = 0; i < 300; i++) send_word("a", 1'b0);
    end_source();
  endtask

  task automatic test_random_source();
    string frags[] = '{"function", "return", "foo_1", "0x3A", "0", "42", "<<", ">>>",
                       "==", "!=", "&&", "||", "::", "=", "|", "&", "^", "~", ":", ";",
                       "{", "}", "(", ")", "[", "]", " ", "\n", "\t", "rEturn", "<<<"};
    int sent;
    sent = 0;
    while (sent < 590) begin
      int r;
      r = $urandom_range(99);
      if (r < 80) begin
        string s;
        s = frags[$urandom_range(frags.size()-1)];
        send_text(s);
        send_word(" ", 1'b0);
        sent += s.len() + 1;
      end else if (r < 92) begin
        send_word(8'($urandom_range(255)), 1'b0);
        sent++;
      end else begin
        send_word(8'($urandom_range(255)), 1'b1);
        sent++;
      end
      if (sent > 250 && sent < 350) quiet = 1; else quiet = 0;
    end
    quiet = 0;
    end_source();
  endtask

  initial begin
    fail_cnt    = 0;
    quiet       = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    lx_clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_keywords_idents();
    test_literals();
    test_operators();
    test_errors();
    test_long_token();
    test_random_source();
    in_valid_i <= 1'b0;
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
